>>> design/dcbd_pkg.sv
// shared types and constants for the drive command byte decoder
`timescale 1ns / 1ps

package dcbd_pkg;

  // direction bit of a sign-magnitude wheel byte
  localparam logic [7:0] DirBit = 8'h80;
  // turn magnitude scale
  localparam logic [3:0] TurnScale = 4'd15;
  // nibble offsets
  localparam logic signed [4:0] XBias = 5'sd8;
  localparam logic signed [3:0] YBias = 4'sd4;
  // base of the translation scale factor
  localparam logic [3:0] FactorBase = 4'd9;

  // high nibble codes of a turn byte
  localparam logic [2:0] HiFireOne   = 3'd1;
  localparam logic [2:0] HiFireTwo   = 3'd2;
  localparam logic [2:0] HiFireThree = 3'd3;

  // second fire code values
  localparam logic [1:0] FireNone  = 2'd0;
  localparam logic [1:0] FireTwo   = 2'd1;
  localparam logic [1:0] FireThree = 2'd2;

  typedef struct packed {
    logic [7:0] turn_left;
    logic [7:0] turn_right;
    logic       fire_first;
    logic [1:0] fire_second;
  } turn_state_t;

  typedef struct packed {
    logic [7:0] front_left;
    logic [7:0] back_left;
    logic [7:0] front_right;
    logic [7:0] back_right;
    logic       fire_first;
    logic [1:0] fire_second;
  } drive_res_t;

endpackage

>>> design/dcbd_if.sv
// handshake channels for command bytes and wheel drive results
`timescale 1ns / 1ps

interface dcbd_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] command_byte;

  modport source (output valid, output command_byte, input ready);
  modport sink (input valid, input command_byte, output ready);
endinterface

interface dcbd_drive_if;
  logic       valid;
  logic       ready;
  logic [7:0] front_left;
  logic [7:0] back_left;
  logic [7:0] front_right;
  logic [7:0] back_right;
  logic       fire_first;
  logic [1:0] fire_second;

  modport source (
    output valid, output front_left, output back_left, output front_right,
    output back_right, output fire_first, output fire_second, input ready
  );
  modport sink (
    input valid, input front_left, input back_left, input front_right,
    input back_right, input fire_first, input fire_second, output ready
  );
endinterface

>>> design/drive_command_byte_decoder.sv
// top level of the drive command byte decoder
`timescale 1ns / 1ps

// Takes one command byte per item and accepts a new item every clock cycle
// unless a translation byte waits on a stalled output. An accepted byte is
// held in an input register; a turn byte (bit 7 clear) then updates the
// latched turn bytes and fire codes and gives no result, a translation byte
// (bit 7 set) is mixed into four wheel bytes that are loaded into the
// result register, which follows the input register, once it is free.
// Throughput is set by the single result register: it is reloaded in the
// cycle it is taken, and input stalls only while a translation byte waits
// in the input register behind a stalled output.
module drive_command_byte_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  dcbd_cmd_if.sink           cmd_i,
  dcbd_drive_if.source       res_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       out_valid_q, out_valid_d;
  dcbd_pkg::drive_res_t out_q;

  logic                  s1_adv;
  logic                  out_free;
  logic                  in_take;
  logic                  turn_upd;
  logic                  out_load;
  dcbd_pkg::turn_state_t turn_state;
  dcbd_pkg::drive_res_t  mix_res;

  always_comb begin
    out_free    = !out_valid_q || res_o.ready;
    // a turn item never waits on the output side
    s1_adv      = s1_valid_q && (!s1_byte_q[7] || out_free);
    cmd_i.ready = !s1_valid_q || s1_adv;
    in_take     = cmd_i.valid && cmd_i.ready;
    turn_upd    = s1_adv && !s1_byte_q[7];
    out_load    = s1_adv && s1_byte_q[7];
    s1_valid_d  = in_take || (s1_valid_q && !s1_adv);
    out_valid_d = out_load || (out_valid_q && !res_o.ready);
  end

  dcbd_turn u_turn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (turn_upd),
    .byte_i  (s1_byte_q),
    .state_o (turn_state)
  );

  dcbd_mix u_mix (
    .byte_i  (s1_byte_q),
    .state_i (turn_state),
    .res_o   (mix_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= cmd_i.command_byte;
    end
    if (out_load) begin
      out_q <= mix_res;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.front_left  = out_q.front_left;
  assign res_o.back_left   = out_q.back_left;
  assign res_o.front_right = out_q.front_right;
  assign res_o.back_right  = out_q.back_right;
  assign res_o.fire_first  = out_q.fire_first;
  assign res_o.fire_second = out_q.fire_second;

endmodule

>>> design/dcbd_turn.sv
// turn byte latches and one-shot fire code logic
`timescale 1ns / 1ps

module dcbd_turn (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 upd_i,
  input  logic [7:0]           byte_i,
  output dcbd_pkg::turn_state_t state_o
);

  logic [7:0] left_q, left_d;
  logic [7:0] right_q, right_d;
  logic       fire1_q, fire1_d;
  logic [1:0] fire2_q, fire2_d;
  logic [2:0] held_q, held_d;

  logic [2:0]        hi;
  logic signed [4:0] lo;
  logic [3:0]        lo_mag;
  logic [7:0]        mag;

  always_comb begin
    hi     = byte_i[6:4];
    lo     = $signed({1'b0, byte_i[3:0]}) - dcbd_pkg::XBias;
    lo_mag = lo[4] ? 4'(-lo) : lo[3:0];
    mag    = 8'(lo_mag * dcbd_pkg::TurnScale);

    left_d  = left_q;
    right_d = right_q;
    fire1_d = fire1_q;
    fire2_d = fire2_q;
    held_d  = held_q;

    if (upd_i) begin
      if (lo[4]) begin
        left_d  = dcbd_pkg::DirBit | mag;
        right_d = mag;
      end else begin
        left_d  = mag;
        right_d = dcbd_pkg::DirBit | mag;
      end
      // a code fires only on the first of a run of equal high nibbles
      fire1_d = (hi == dcbd_pkg::HiFireOne) && !held_q[0];
      priority if ((hi == dcbd_pkg::HiFireTwo) && !held_q[1]) begin
        fire2_d = dcbd_pkg::FireTwo;
      end else if ((hi == dcbd_pkg::HiFireThree) && !held_q[2]) begin
        fire2_d = dcbd_pkg::FireThree;
      end else begin
        fire2_d = dcbd_pkg::FireNone;
      end
      held_d = {hi == dcbd_pkg::HiFireThree, hi == dcbd_pkg::HiFireTwo,
                hi == dcbd_pkg::HiFireOne};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
      fire1_q <= 1'b0;
      fire2_q <= dcbd_pkg::FireNone;
      held_q  <= '0;
    end else begin
      left_q  <= left_d;
      right_q <= right_d;
      fire1_q <= fire1_d;
      fire2_q <= fire2_d;
      held_q  <= held_d;
    end
  end

  assign state_o.turn_left   = left_q;
  assign state_o.turn_right  = right_q;
  assign state_o.fire_first  = fire1_q;
  assign state_o.fire_second = fire2_q;

endmodule

>>> design/dcbd_mix.sv
// translation mixing into four wheel bytes, with turn priority
`timescale 1ns / 1ps

module dcbd_mix (
  input  logic [7:0]            byte_i,
  input  dcbd_pkg::turn_state_t state_i,
  output dcbd_pkg::drive_res_t  res_o
);

  function automatic logic [7:0] drive_byte(input logic signed [10:0] v);
    logic [10:0] mag;
    mag = v[10] ? 11'(-v) : 11'(v);
    return {v[10], mag[5:0], 1'b0};
  endfunction

  logic [2:0]         hi;
  logic signed [3:0]  y;
  logic signed [4:0]  x;
  logic [3:0]         x_mag;
  logic [3:0]         x_div;
  logic [3:0]         fac;
  logic signed [5:0]  s_sum;
  logic signed [5:0]  s_dif;
  logic signed [10:0] a_v;
  logic signed [10:0] b_v;
  logic [7:0]         da;
  logic [7:0]         db;

  always_comb begin
    hi    = byte_i[6:4];
    y     = $signed({1'b0, hi}) - dcbd_pkg::YBias;
    x     = $signed({1'b0, byte_i[3:0]}) - dcbd_pkg::XBias;
    x_mag = x[4] ? 4'(-x) : x[3:0];
    // full-scale y (hi nibble zero) divides by one, else by two
    x_div = (hi == 3'd0) ? x_mag : (x_mag >> 1);
    fac   = dcbd_pkg::FactorBase - x_div;
    s_sum = 6'(y) + 6'(x);
    s_dif = 6'(y) - 6'(x);
    a_v   = 11'sd0 - (11'(s_sum) * $signed({7'd0, fac}));
    b_v   = 11'sd0 - (11'(s_dif) * $signed({7'd0, fac}));
    da    = drive_byte(a_v);
    db    = drive_byte(b_v);

    if (state_i.turn_left[6:0] == 7'd0) begin
      res_o.front_left  = da;
      res_o.back_right  = da;
      res_o.front_right = db;
      res_o.back_left   = db;
    end else begin
      res_o.front_left  = state_i.turn_left;
      res_o.back_left   = state_i.turn_left;
      res_o.front_right = state_i.turn_right;
      res_o.back_right  = state_i.turn_right;
    end
    res_o.fire_first  = state_i.fire_first;
    res_o.fire_second = state_i.fire_second;
  end

endmodule

>>> tb/sv/drive_command_byte_decoder_tb.sv
// self-checking testbench for the drive command byte decoder
`timescale 1ns / 1ps

module drive_command_byte_decoder_tb;

  localparam int NumRandom  = 1750;
  localparam int IdleLimit  = 4000;
  localparam int DrainTicks = 12;

  // tracks turn and fire state and holds the wheel bytes each translation item should give
  class drive_scoreboard;
    logic [7:0]  turn_left;
    logic [7:0]  turn_right;
    logic        fire_first;
    logic [1:0]  fire_second;
    logic [2:0]  held;
    dcbd_pkg::drive_res_t expected_drive[$];
    int          mismatches;

    function new();
      turn_left   = '0;
      turn_right  = '0;
      fire_first  = 1'b0;
      fire_second = dcbd_pkg::FireNone;
      held        = '0;
      mismatches  = 0;
    endfunction

    function logic [7:0] wheel_byte(int v);
      int mag;
      mag = (v < 0) ? -v : v;
      return ((v < 0) ? dcbd_pkg::DirBit : 8'h00) | 8'((mag * 2) & 8'h7f);
    endfunction

    function void note_command(logic [7:0] cmd);
      logic [2:0] hi;
      int         lo;
      int         mag;
      int         y;
      int         div;
      int         fac;
      int         a;
      int         b;
      logic       f1;
      logic [1:0] f2;
      dcbd_pkg::drive_res_t res;
      hi = cmd[6:4];
      lo = int'(cmd[3:0]) - int'(dcbd_pkg::XBias);
      if (!cmd[7]) begin
        mag = ((lo < 0) ? -lo : lo) * int'(dcbd_pkg::TurnScale);
        if (lo < 0) begin
          turn_left  = dcbd_pkg::DirBit | 8'(mag);
          turn_right = 8'(mag);
        end else begin
          turn_left  = 8'(mag);
          turn_right = dcbd_pkg::DirBit | 8'(mag);
        end
        f1 = 1'b0;
        f2 = dcbd_pkg::FireNone;
        // one-shot: a code fires only on its first arrival in a row
        if (hi == dcbd_pkg::HiFireOne && !held[0]) begin
          f1      = 1'b1;
          held[0] = 1'b1;
        end
        if (hi != dcbd_pkg::HiFireOne) held[0] = 1'b0;
        if (hi == dcbd_pkg::HiFireTwo && !held[1]) begin
          f2      = dcbd_pkg::FireTwo;
          held[1] = 1'b1;
        end else if (hi == dcbd_pkg::HiFireThree && !held[2]) begin
          f2      = dcbd_pkg::FireThree;
          held[2] = 1'b1;
        end
        if (hi != dcbd_pkg::HiFireThree) held[2] = 1'b0;
        if (hi != dcbd_pkg::HiFireTwo) held[1] = 1'b0;
        fire_first  = f1;
        fire_second = f2;
        return;
      end
      y   = int'(hi) - int'(dcbd_pkg::YBias);
      div = (y == -4 || y == 4) ? 1 : 2;
      fac = int'(dcbd_pkg::FactorBase) - ((lo < 0) ? -lo : lo) / div;
      a   = -((y + lo) * fac);
      b   = -((y - lo) * fac);
      // latched turn wins unless its magnitude is zero
      if (turn_left[6:0] == 7'd0) begin
        res.front_left  = wheel_byte(a);
        res.back_right  = wheel_byte(a);
        res.front_right = wheel_byte(b);
        res.back_left   = wheel_byte(b);
      end else begin
        res.front_left  = turn_left;
        res.back_left   = turn_left;
        res.front_right = turn_right;
        res.back_right  = turn_right;
      end
      res.fire_first  = fire_first;
      res.fire_second = fire_second;
      expected_drive.push_back(res);
    endfunction

    function void check_drive(dcbd_pkg::drive_res_t got);
      dcbd_pkg::drive_res_t want;
      if (expected_drive.size() == 0) begin
        $display("%0t: unexpected drive item fl=%h bl=%h fr=%h br=%h f1=%0d f2=%0d",
                 $time, got.front_left, got.back_left, got.front_right, got.back_right,
                 got.fire_first, got.fire_second);
        mismatches++;
        return;
      end
      want = expected_drive.pop_front();
      if (got.front_left !== want.front_left) begin
        $display("%0t: front_left expected %h actual %h", $time, want.front_left,
                 got.front_left);
        mismatches++;
      end
      if (got.back_left !== want.back_left) begin
        $display("%0t: back_left expected %h actual %h", $time, want.back_left,
                 got.back_left);
        mismatches++;
      end
      if (got.front_right !== want.front_right) begin
        $display("%0t: front_right expected %h actual %h", $time, want.front_right,
                 got.front_right);
        mismatches++;
      end
      if (got.back_right !== want.back_right) begin
        $display("%0t: back_right expected %h actual %h", $time, want.back_right,
                 got.back_right);
        mismatches++;
      end
      if (got.fire_first !== want.fire_first) begin
        $display("%0t: fire_first expected %0d actual %0d", $time, want.fire_first,
                 got.fire_first);
        mismatches++;
      end
      if (got.fire_second !== want.fire_second) begin
        $display("%0t: fire_second expected %0d actual %0d", $time, want.fire_second,
                 got.fire_second);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic steady;
  int   idle_cycles;

  drive_scoreboard sb;

  dcbd_cmd_if   cmd_if ();
  dcbd_drive_if drive_if ();

  drive_command_byte_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (drive_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one, none while steady
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_command(input logic [7:0] cmd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.command_byte <= cmd;
    do @(posedge clk_i); while (!cmd_if.ready);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] random_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return {1'b1, 7'($urandom_range(0, 127))};
    // neutral turn keeps the mixer path open while exercising the fire codes
    if (r < 62) return {1'b0, 3'($urandom_range(0, 7)), 4'h8};
    if (r < 72) return {1'b0, 3'($urandom_range(1, 3)), 4'($urandom_range(0, 15))};
    return 8'($urandom_range(0, 255));
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    dcbd_pkg::drive_res_t got;
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (drive_if.valid && drive_if.ready) begin
        got.front_left  = drive_if.front_left;
        got.back_left   = drive_if.back_left;
        got.front_right = drive_if.front_right;
        got.back_right  = drive_if.back_right;
        got.fire_first  = drive_if.fire_first;
        got.fire_second = drive_if.fire_second;
        sb.check_drive(got);
      end
      if (cmd_if.valid && cmd_if.ready) sb.note_command(cmd_if.command_byte);
      if ((drive_if.valid && drive_if.ready) || (cmd_if.valid && cmd_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side back-pressure
  initial begin
    int gap;
    drive_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        drive_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      drive_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  initial begin
    logic [7:0] directed[$];
    sb                  = new();
    steady              = 1'b0;
    rst_ni              = 1'b0;
    cmd_if.valid        = 1'b0;
    cmd_if.command_byte = 8'h00;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // neutral turn, field extremes, hard turns, one-shot fire codes and their release
    directed = '{8'h80, 8'hff, 8'h88, 8'h8f, 8'hf0, 8'hc8, 8'h08, 8'hb0,
                 8'h00, 8'h88, 8'h0f, 8'h88, 8'h18, 8'h18, 8'h88, 8'h28,
                 8'h28, 8'h38, 8'h88, 8'h38, 8'h28, 8'h7f, 8'h48, 8'h98};
    foreach (directed[i]) send_command(directed[i]);

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      send_command(random_command());
    end
    cmd_if.valid <= 1'b0;

    while (sb.expected_drive.size() != 0) @(posedge clk_i);
    repeat (DrainTicks) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_drive.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
